>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define PMCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PMCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/pmct_pkg.sv
// Shared types and constants for the PS/2 mouse cursor tracker.
package pmct_pkg;

   localparam int SIZE_BITS     = 13;
   localparam int BYTE_BITS     = 8;
   localparam int OUT_BITS      = 12;
   localparam int CSR_IDX_BITS  = 1;

   // Header byte bit positions
   localparam int HDR_LEFT      = 0;
   localparam int HDR_RIGHT     = 1;
   localparam int HDR_MIDDLE    = 2;
   localparam int HDR_SYNC      = 3;
   localparam int HDR_X_SIGN    = 4;
   localparam int HDR_Y_SIGN    = 5;
   localparam int HDR_X_OVF     = 6;
   localparam int HDR_Y_OVF     = 7;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_X      = 3'b010,
      PHASE_Y      = 3'b100
   } phase_type;

   // Framer status toward the cursor unit and the result stage
   typedef struct packed {
      logic                 last;
      logic [BYTE_BITS-1:0] header;
      logic [BYTE_BITS-1:0] x_move;
   } frame_type;

   // 10-bit signed movement: 9-bit two's complement plus the overflow step
   function automatic logic signed [9:0] delta10(input logic [BYTE_BITS-1:0] mag,
                                                input logic sign, input logic ovf);
      logic signed [9:0] d;
      d = signed'({2'b00, mag});
      if (sign) begin
         d = d - 10'sd256;
         if (ovf) begin
            d = d - 10'sd256;
         end
      end else if (ovf) begin
         d = d + 10'sd256;
      end
      return d;
   endfunction

endpackage

>>> rtl/pmct_framer.sv
// Packet framer: header sync and capture of the header and X movement bytes.
module pmct_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [pmct_pkg::BYTE_BITS-1:0] rx_byte,
   output pmct_pkg::frame_type           frame
);

   pmct_pkg::phase_type                phase_ff, phase_in;
   logic [pmct_pkg::BYTE_BITS-1:0]     header_ff, header_in;
   logic [pmct_pkg::BYTE_BITS-1:0]     x_move_ff, x_move_in;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      x_move_in = x_move_ff;
      if (step) begin
         unique case (phase_ff)
            pmct_pkg::PHASE_HEADER: begin
               if (rx_byte[pmct_pkg::HDR_SYNC]) begin
                  header_in = rx_byte;
                  phase_in  = pmct_pkg::PHASE_X;
               end
            end
            pmct_pkg::PHASE_X: begin
               x_move_in = rx_byte;
               phase_in  = pmct_pkg::PHASE_Y;
            end
            pmct_pkg::PHASE_Y: begin
               phase_in = pmct_pkg::PHASE_HEADER;
            end
            default: begin
               phase_in = pmct_pkg::PHASE_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pmct_pkg::PHASE_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      x_move_ff <= x_move_in;
   end

   assign frame.last   = (phase_ff == pmct_pkg::PHASE_Y);
   assign frame.header = header_ff;
   assign frame.x_move = x_move_ff;

endmodule

>>> rtl/pmct_cursor.sv
// Cursor unit: movement deltas, position update and screen clamp.
module pmct_cursor #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           update,
   input  pmct_pkg::frame_type            frame,
   input  logic [pmct_pkg::BYTE_BITS-1:0] y_move,
   input  logic [pmct_pkg::SIZE_BITS-1:0] screen_width,
   input  logic [pmct_pkg::SIZE_BITS-1:0] screen_height,
   output logic [COORD_BITS-1:0]          next_x,
   output logic [COORD_BITS-1:0]          next_y
);

   localparam int SPAN = (COORD_BITS > pmct_pkg::SIZE_BITS) ? COORD_BITS : pmct_pkg::SIZE_BITS;
   localparam int PW   = SPAN + 3;
   localparam logic [PW-1:0] TOP = {{(PW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [9:0]     dx, dy;
   logic signed [PW-1:0]  raw_x, raw_y;

   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [PW-1:0] p,
                                                   input logic [pmct_pkg::SIZE_BITS-1:0] size);
      logic [pmct_pkg::SIZE_BITS-1:0] lim_raw;
      logic [PW-1:0]                  lim;
      logic [PW-1:0]                  res;
      lim_raw = (size == '0) ? '0 : size - 1'b1;
      lim     = PW'(lim_raw);
      if (lim > TOP) begin
         lim = TOP;
      end
      if (p < 0) begin
         res = '0;
      end else if (unsigned'(p) > lim) begin
         res = lim;
      end else begin
         res = unsigned'(p);
      end
      return res[COORD_BITS-1:0];
   endfunction

   always_comb begin
      dx     = pmct_pkg::delta10(frame.x_move, frame.header[pmct_pkg::HDR_X_SIGN],
                                 frame.header[pmct_pkg::HDR_X_OVF]);
      dy     = pmct_pkg::delta10(y_move, frame.header[pmct_pkg::HDR_Y_SIGN],
                                 frame.header[pmct_pkg::HDR_Y_OVF]);
      // screen y grows downward, mouse y grows upward
      raw_x  = signed'(PW'(pos_x_ff)) + PW'(dx);
      raw_y  = signed'(PW'(pos_y_ff)) - PW'(dy);
      next_x = clamp(raw_x, screen_width);
      next_y = clamp(raw_y, screen_height);
      pos_x_in = update ? next_x : pos_x_ff;
      pos_y_in = update ? next_y : pos_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

endmodule

>>> rtl/ps2_mouse_packet_cursor_tracker.sv
// Flow: a request reaches the input register, and when the third byte of a packet advances
// from there, its result is loaded into the result register, which drives rsp_valid.
// Throughput: one request per cycle; the input register and the result register decouple
// the two sides, so a waiting result stalls input only when the next byte also closes a packet.
// Reset (synchronous, active high): framer waits for a header, cursor at 0,0,
// screen size 1024 by 768, both channel registers empty.
module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte requests from the mouse link
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pmct_pkg::BYTE_BITS-1:0]    req_rx_byte,
   // cursor results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pmct_pkg::OUT_BITS-1:0]     rsp_cursor_x,
   output logic [pmct_pkg::OUT_BITS-1:0]     rsp_cursor_y,
   output logic                              rsp_left_button,
   output logic                              rsp_right_button,
   output logic                              rsp_middle_button,
   output logic                              rsp_x_overflowed,
   output logic                              rsp_y_overflowed,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmct_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pmct_pkg::SIZE_BITS-1:0]    csr_wdata
);

   // Screen size registers
   logic [pmct_pkg::SIZE_BITS-1:0] width_ff, width_in;
   logic [pmct_pkg::SIZE_BITS-1:0] height_ff, height_in;

   // Input register
   logic                           in_valid_ff, in_valid_in;
   logic [pmct_pkg::BYTE_BITS-1:0] in_byte_ff, in_byte_in;

   // Result register
   logic                           out_valid_ff, out_valid_in;
   logic [pmct_pkg::OUT_BITS-1:0]  out_x_ff, out_x_in;
   logic [pmct_pkg::OUT_BITS-1:0]  out_y_ff, out_y_in;
   logic [4:0]                     out_flags_ff, out_flags_in;

   pmct_pkg::frame_type            frame;
   logic                           advance;
   logic                           load_result;
   logic [COORD_BITS-1:0]          next_x, next_y;

   // Take register writes at any time; software writes only while idle.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pmct_pkg::CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            pmct_pkg::CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the held byte unless it closes a packet while the result slot stays full.
   assign advance     = in_valid_ff && (!frame.last || !out_valid_ff || rsp_ready);
   assign load_result = advance && frame.last;
   assign req_ready   = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
   end

   pmct_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .frame   (frame)
   );

   pmct_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .update        (load_result),
      .frame         (frame),
      .y_move        (in_byte_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .next_x        (next_x),
      .next_y        (next_y)
   );

   // Fill the result slot on a closing byte, drop it once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_flags_in = out_flags_ff;
      if (load_result) begin
         out_valid_in = 1'b1;
         out_x_in     = pmct_pkg::OUT_BITS'(next_x);
         out_y_in     = pmct_pkg::OUT_BITS'(next_y);
         out_flags_in = {frame.header[pmct_pkg::HDR_Y_OVF],
                         frame.header[pmct_pkg::HDR_X_OVF],
                         frame.header[pmct_pkg::HDR_MIDDLE],
                         frame.header[pmct_pkg::HDR_RIGHT],
                         frame.header[pmct_pkg::HDR_LEFT]};
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pmct_pkg::WIDTH_RESET;
         height_ff    <= pmct_pkg::HEIGHT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_cursor_x      = out_x_ff;
   assign rsp_cursor_y      = out_y_ff;
   assign rsp_left_button   = out_flags_ff[0];
   assign rsp_right_button  = out_flags_ff[1];
   assign rsp_middle_button = out_flags_ff[2];
   assign rsp_x_overflowed  = out_flags_ff[3];
   assign rsp_y_overflowed  = out_flags_ff[4];

endmodule

>>> rtl/pmct_checker.sv
// Port-level checker for the cursor tracker, bound to the top level.
`include "assert_macros.svh"

module pmct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pmct_pkg::OUT_BITS-1:0]     rsp_cursor_x,
   input logic [pmct_pkg::OUT_BITS-1:0]     rsp_cursor_y
);

   // A reset empties the result slot.
   `PMCT_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   // A fresh result traces back to a request taken into the input register before the result register was loaded.
   `PMCT_ASSERT(a_result_source, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2),
                "result without a request two cycles before")

   // A stalled result holds its position.
   `PMCT_ASSERT(a_result_hold, rsp_valid && !rsp_ready |=>
                rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y),
                "stalled result changed")

endmodule

bind ps2_mouse_packet_cursor_tracker pmct_checker u_pmct_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_cursor_x (rsp_cursor_x),
   .rsp_cursor_y (rsp_cursor_y)
);
